// ===== hw/rtl/cda_pkg.sv =====
// Shared types and constants for the calendar date adder.
// Used by cda_div, cda_mlen, calendar_date_adder and the dv checker and bench; depends on nothing.
package cda_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_SET_DATE   = 2'd0,
        CMD_ADD_DAYS   = 2'd1,
        CMD_ADD_MONTHS = 2'd2,
        CMD_ADD_YEARS  = 2'd3
    } cmd_t;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMOUNT_W = 16;
    localparam int MLEN_W   = 5;

    // Divider: dividend covers (month - 1) + amount and any year value
    localparam int DIVIDEND_W = AMOUNT_W + 1;
    localparam int DIVISOR_W  = 9;

    // Reciprocals: floor(x*RECIP >> SHIFT) exact by 12 for any dividend, by 400 for any year
    localparam int RECIP_W = 16;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_12        = RECIP_W'(43691);
    localparam int                 RECIP_12_SHIFT  = 19;
    localparam logic [RECIP_W-1:0] RECIP_400       = RECIP_W'(10486);
    localparam int                 RECIP_400_SHIFT = 22;

    localparam logic [RECIP_W-1:0] MONTHS_PER_YEAR = RECIP_W'(12);
    localparam logic [RECIP_W-1:0] LEAP_CYCLE      = RECIP_W'(400);

    // Divisor select
    typedef enum logic {
        DIV_MONTHS,
        DIV_LEAP
    } div_sel_t;

    // Year residues mod 400 that are multiples of 100 but not of 400, and the last residue
    localparam logic [DIVISOR_W-1:0] CENT_1 = DIVISOR_W'(100);
    localparam logic [DIVISOR_W-1:0] CENT_2 = DIVISOR_W'(200);
    localparam logic [DIVISOR_W-1:0] CENT_3 = DIVISOR_W'(300);
    localparam logic [DIVISOR_W-1:0] LAST_RES = DIVISOR_W'(399);

    // Reset date
    localparam logic [YEAR_W-1:0]    YEAR_RESET      = YEAR_W'(2000);
    localparam logic [DIVISOR_W-1:0] YEAR_RESET_R400 = DIVISOR_W'(2000 % 400);
    localparam logic [MONTH_W-1:0]   MONTH_RESET     = MONTH_W'(1);
    localparam logic [DAY_W-1:0]     DAY_RESET       = DAY_W'(1);

    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);

    localparam logic [MLEN_W-1:0] FEB_LEAP = MLEN_W'(29);

    // Days per month, common year, January first
    localparam logic [MLEN_W-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Divider request and answer
    typedef struct packed {
        logic                  start;
        div_sel_t              sel;
        logic [DIVIDEND_W-1:0] dividend;
    } div_ctl_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVISOR_W-1:0]  rem;
    } div_stat_t;

endpackage

// ===== hw/rtl/calendar_date_adder.sv =====
// Calendar date adder: holds one date, applies set / add days / add months / add years.
// Add months makes two passes of the shared constant divider (by 12, then the year residue
// by 400); set and add years make the year-residue pass only; add days walks one month at a
// time. s_tready high only while idle: a new item waits until the last result is loaded.
// Reset (aresetn low, synchronous) loads 2000-01-01 and clears the output channel.
// Depends on cda_pkg, cda_div, cda_mlen.
module calendar_date_adder #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // year_value[13:0], month_value[17:14], day_value[22:18],
                                  // amount[38:23], zero[39]
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                  // month_length[27:23], zero[31:28]
    output logic [0:0]  m_tuser   // year_saturated[0]
);
    import cda_pkg::*;

    localparam logic [YEAR_W+3:0]    YMAX_EXT  = (YEAR_W + 4)'(YEAR_MAX);
    localparam logic [YEAR_W-1:0]    YMAX      = YEAR_W'(YEAR_MAX);
    localparam logic [DIVISOR_W-1:0] YMAX_R400 = DIVISOR_W'(YEAR_MAX % 400);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_MSTART,
        ST_MWAIT,
        ST_YSTART,
        ST_YWAIT,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [YEAR_W-1:0]     year_reg, year_next;
    logic [MONTH_W-1:0]    month_reg, month_next;
    logic [DAY_W-1:0]      day_reg, day_next;
    logic [DIVISOR_W-1:0]  r400_reg, r400_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic                  sat_reg, sat_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [31:0]           m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    // Input item fields
    logic [1:0]            in_cmd;
    logic [YEAR_W-1:0]     in_year;
    logic [MONTH_W-1:0]    in_month;
    logic [DAY_W-1:0]      in_day;
    logic [AMOUNT_W-1:0]   in_amount;
    logic                  in_accept;

    // Shared year adder
    logic [YEAR_W+3:0]     yr_inc;
    logic [YEAR_W+3:0]     yr_sum;
    logic                  yr_over;

    // Day walk
    logic [MLEN_W-1:0]     mlen;
    logic [DIVIDEND_W-1:0] day_sum;
    logic [DIVIDEND_W-1:0] len_ext;

    div_ctl_t              div_ctl;
    div_stat_t             div_stat;

    assign in_cmd    = s_tuser;
    assign in_year   = s_tdata[13:0];
    assign in_month  = s_tdata[17:14];
    assign in_day    = s_tdata[22:18];
    assign in_amount = s_tdata[38:23];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    cda_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .stat    (div_stat)
    );

    cda_mlen u_mlen (
        .month        (month_reg),
        .year_lo      (year_reg[1:0]),
        .year_r400    (r400_reg),
        .month_length (mlen)
    );

    // Divider request: months carry by 12, year residue by 400
    always_comb begin
        div_ctl.start    = (state_reg == ST_MSTART) || (state_reg == ST_YSTART);
        div_ctl.sel      = DIV_LEAP;
        div_ctl.dividend = (DIVIDEND_W)'(year_reg);
        if (state_reg == ST_MSTART) begin
            div_ctl.sel      = DIV_MONTHS;
            div_ctl.dividend = rem_reg + (DIVIDEND_W)'(month_reg - MONTH_W'(1));
        end
    end

    // Year increment source and clamp check
    always_comb begin
        unique case (state_reg)
            ST_MWAIT: yr_inc = (YEAR_W + 4)'(div_stat.quot);
            ST_DAYS:  yr_inc = (YEAR_W + 4)'(1);
            default:  yr_inc = (YEAR_W + 4)'(in_amount);
        endcase
        yr_sum  = (YEAR_W + 4)'(year_reg) + yr_inc;
        yr_over = (yr_sum > YMAX_EXT);
    end

    always_comb begin
        day_sum = (DIVIDEND_W)'(day_reg) + rem_reg;
        len_ext = (DIVIDEND_W)'(mlen);
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        r400_next     = r400_reg;
        rem_next      = rem_reg;
        sat_next      = sat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    sat_next = 1'b0;
                    rem_next = (DIVIDEND_W)'(in_amount);
                    unique case (cmd_t'(in_cmd))
                        CMD_SET_DATE: begin
                            if ((YEAR_W + 4)'(in_year) > YMAX_EXT) begin
                                year_next = YMAX;
                                sat_next  = 1'b1;
                            end else begin
                                year_next = in_year;
                            end
                            if (in_month < MONTH_FIRST) begin
                                month_next = MONTH_FIRST;
                            end else if (in_month > MONTH_LAST) begin
                                month_next = MONTH_LAST;
                            end else begin
                                month_next = in_month;
                            end
                            day_next   = in_day;
                            state_next = ST_YSTART;
                        end
                        CMD_ADD_DAYS: begin
                            state_next = ST_DAYS;
                        end
                        CMD_ADD_MONTHS: begin
                            state_next = ST_MSTART;
                        end
                        CMD_ADD_YEARS: begin
                            if (yr_over) begin
                                year_next = YMAX;
                                sat_next  = 1'b1;
                            end else begin
                                year_next = yr_sum[YEAR_W-1:0];
                            end
                            state_next = ST_YSTART;
                        end
                    endcase
                end
            end
            // One month per cycle until the remaining days fit
            ST_DAYS: begin
                if (day_sum <= len_ext) begin
                    day_next   = day_sum[DAY_W-1:0];
                    state_next = ST_EMIT;
                end else begin
                    rem_next = day_sum - len_ext - (DIVIDEND_W)'(1);
                    day_next = DAY_RESET;
                    if (month_reg == MONTH_LAST) begin
                        month_next = MONTH_FIRST;
                        if (yr_over) begin
                            year_next = YMAX;
                            r400_next = YMAX_R400;
                            sat_next  = 1'b1;
                        end else begin
                            year_next = yr_sum[YEAR_W-1:0];
                            r400_next = (r400_reg == LAST_RES) ? '0
                                                               : r400_reg + DIVISOR_W'(1);
                        end
                    end else begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end
            end
            ST_MSTART: begin
                state_next = ST_MWAIT;
            end
            // Quotient carries into the year, remainder plus one is the new month
            ST_MWAIT: begin
                if (div_stat.done) begin
                    month_next = MONTH_W'(div_stat.rem) + MONTH_W'(1);
                    if (yr_over) begin
                        year_next = YMAX;
                        sat_next  = 1'b1;
                    end else begin
                        year_next = yr_sum[YEAR_W-1:0];
                    end
                    state_next = ST_YSTART;
                end
            end
            ST_YSTART: begin
                state_next = ST_YWAIT;
            end
            ST_YWAIT: begin
                if (div_stat.done) begin
                    r400_next  = div_stat.rem;
                    state_next = ST_EMIT;
                end
            end
            // Load the output register once it is free
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, mlen, day_reg, month_reg, year_reg};
                    m_tuser_next  = sat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            year_reg     <= YEAR_RESET;
            month_reg    <= MONTH_RESET;
            day_reg      <= DAY_RESET;
            r400_reg     <= YEAR_RESET_R400;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            r400_reg     <= r400_next;
            sat_reg      <= sat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/cda_div.sv =====
// Shared divider by 12 or 400: reciprocal multiply for the quotient, then the remainder.
// One multiplier serves both passes; depends on cda_pkg (div_ctl_t, div_stat_t, constants).
module cda_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  cda_pkg::div_ctl_t  ctl,
    output cda_pkg::div_stat_t stat
);
    import cda_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUOT,
        PH_REM
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  done_reg, done_next;
    div_sel_t              sel_reg, sel_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] mul_a;
    logic [RECIP_W-1:0]    mul_b;
    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] diff;

    // Shared multiplier: reciprocal in the quotient pass, divisor in the remainder pass
    always_comb begin
        if (phase_reg == PH_REM) begin
            mul_a = quot_reg;
            mul_b = (sel_reg == DIV_MONTHS) ? MONTHS_PER_YEAR : LEAP_CYCLE;
        end else begin
            mul_a = num_reg;
            mul_b = (sel_reg == DIV_MONTHS) ? RECIP_12 : RECIP_400;
        end
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        diff = num_reg - prod[DIVIDEND_W-1:0];
    end

    // Capture, quotient pass, remainder pass
    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        sel_next   = sel_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (ctl.start) begin
                    sel_next   = ctl.sel;
                    num_next   = ctl.dividend;
                    phase_next = PH_QUOT;
                end
            end
            PH_QUOT: begin
                if (sel_reg == DIV_MONTHS) begin
                    quot_next = DIVIDEND_W'(prod >> RECIP_12_SHIFT);
                end else begin
                    quot_next = DIVIDEND_W'(prod >> RECIP_400_SHIFT);
                end
                phase_next = PH_REM;
            end
            PH_REM: begin
                rem_next   = diff[DIVISOR_W-1:0];
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        sel_reg  <= sel_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;
    assign stat.rem  = rem_reg;

endmodule

// ===== hw/rtl/cda_mlen.sv =====
// Month length lookup with the Gregorian leap rule.
// Depends on cda_pkg (MONTH_DAYS table, residue constants).
module cda_mlen (
    input  logic [cda_pkg::MONTH_W-1:0]   month,
    input  logic [1:0]                    year_lo,
    input  logic [cda_pkg::DIVISOR_W-1:0] year_r400,
    output logic [cda_pkg::MLEN_W-1:0]    month_length
);
    import cda_pkg::*;

    logic       leap;
    logic [3:0] idx;

    // Leap: divisible by 4, and not a century unless divisible by 400
    always_comb begin
        leap = (year_lo == 2'b00) &&
               !((year_r400 == CENT_1) || (year_r400 == CENT_2) || (year_r400 == CENT_3));
    end

    // Out-of-range months read as January
    always_comb begin
        if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
            idx = month - MONTH_W'(1);
        end else begin
            idx = '0;
        end
        if (month == MONTH_FEB && leap) begin
            month_length = FEB_LEAP;
        end else begin
            month_length = MONTH_DAYS[idx];
        end
    end

endmodule

// ===== dv/calendar_date_checker.sv =====
// Checker for the calendar date adder: watches both item channels, predicts each result
// and compares it field by field. Depends on cda_pkg; instantiated by tb_calendar_date_adder.
`timescale 1ns / 1ps

module calendar_date_checker #(
    parameter int YEAR_MAX = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,  // year_value[13:0], month_value[17:14], day_value[22:18],
                                  // amount[38:23], zero[39]
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,  // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                  // month_length[27:23], zero[31:28]
    input  logic [0:0]  m_tuser,  // year_saturated[0]
    output int          n_errors,
    output int          n_pending
);
    import cda_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [MLEN_W-1:0]  mlen;
        logic               sat;
    } date_out_t;

    // Predicted calendar state
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;

    date_out_t date_q[$];
    int        err_count = 0;

    // Gregorian leap rule, including the 400-year case
    function automatic int days_in(int y, int m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Years clamp at YEAR_MAX; returns 1 when clamped
    function automatic bit bump_years(int inc);
        int y;
        y = int'(cal_year) + inc;
        if (y > YEAR_MAX) begin
            cal_year = YEAR_W'(YEAR_MAX);
            return 1'b1;
        end
        cal_year = YEAR_W'(y);
        return 1'b0;
    endfunction

    function automatic bit bump_months(int inc);
        int total;
        bit sat;
        total     = int'(cal_month) - 1 + inc;
        sat       = bump_years(total / 12);
        cal_month = MONTH_W'(total % 12 + 1);
        return sat;
    endfunction

    // Walk forward one month at a time; excess days in the start month roll over too
    function automatic bit advance_days(int inc);
        int rem;
        int len;
        bit sat;
        rem = inc;
        sat = 1'b0;
        len = days_in(int'(cal_year), int'(cal_month));
        while (int'(cal_day) + rem > len) begin
            rem     = rem + int'(cal_day) - len - 1;
            cal_day = DAY_W'(1);
            if (bump_months(1))
                sat = 1'b1;
            len = days_in(int'(cal_year), int'(cal_month));
        end
        cal_day = DAY_W'(int'(cal_day) + rem);
        return sat;
    endfunction

    function automatic date_out_t apply_item(cmd_t cmd, logic [YEAR_W-1:0] yv,
                                             logic [MONTH_W-1:0] mv, logic [DAY_W-1:0] dv,
                                             logic [AMOUNT_W-1:0] amt);
        date_out_t res;
        res.sat = 1'b0;
        case (cmd)
            CMD_SET_DATE: begin
                res.sat   = (int'(yv) > YEAR_MAX);
                cal_year  = res.sat ? YEAR_W'(YEAR_MAX) : yv;
                cal_month = (mv < MONTH_FIRST) ? MONTH_FIRST :
                            (mv > MONTH_LAST) ? MONTH_LAST : mv;
                cal_day   = dv;
            end
            CMD_ADD_DAYS:   res.sat = advance_days(int'(amt));
            CMD_ADD_MONTHS: res.sat = bump_months(int'(amt));
            default:        res.sat = bump_years(int'(amt));
        endcase
        res.year  = cal_year;
        res.month = cal_month;
        res.day   = cal_day;
        res.mlen  = MLEN_W'(days_in(int'(cal_year), int'(cal_month)));
        return res;
    endfunction

    task automatic compare_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expv, actv);
            err_count++;
        end
    endtask

    // Predict on input items, compare on result items
    always @(posedge aclk) begin
        date_out_t want;
        if (!aresetn) begin
            cal_year  = YEAR_RESET;
            cal_month = MONTH_RESET;
            cal_day   = DAY_RESET;
            date_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                date_q.push_back(apply_item(cmd_t'(s_tuser), s_tdata[13:0], s_tdata[17:14],
                                            s_tdata[22:18], s_tdata[38:23]));
            if (m_tvalid && m_tready) begin
                if (date_q.size() == 0) begin
                    $display("%0t: result item with none expected: tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = date_q.pop_front();
                    compare_field("cur_year", int'(want.year), int'(m_tdata[13:0]));
                    compare_field("cur_month", int'(want.month), int'(m_tdata[17:14]));
                    compare_field("cur_day", int'(want.day), int'(m_tdata[22:18]));
                    compare_field("month_length", int'(want.mlen), int'(m_tdata[27:23]));
                    compare_field("padding", 0, int'(m_tdata[31:28]));
                    compare_field("year_saturated", int'(want.sat), int'(m_tuser[0]));
                end
            end
        end
        n_pending <= date_q.size();
        n_errors  <= err_count;
    end

endmodule

// ===== dv/tb_calendar_date_adder.sv =====
// Top of the calendar date adder testbench: clock, reset, item stimulus and verdict.
// Depends on cda_pkg, calendar_date_adder and calendar_date_checker.
`timescale 1ns / 1ps

module tb_calendar_date_adder;
    import cda_pkg::*;

    localparam int YEAR_LIMIT = 9999;
    localparam int N_RANDOM   = 250;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    int          n_errors;
    int          n_pending;

    // When set, neither side idles
    bit          steady = 1'b0;

    calendar_date_adder #(
        .YEAR_MAX (YEAR_LIMIT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    calendar_date_checker #(
        .YEAR_MAX (YEAR_LIMIT)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Called at a clock edge; returns at the edge where the item is taken
    task automatic send_item(input cmd_t cmd, input logic [YEAR_W-1:0] yv,
                             input logic [MONTH_W-1:0] mv, input logic [DAY_W-1:0] dv,
                             input logic [AMOUNT_W-1:0] amt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, amt, dv, mv, yv};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side: random stall before each item
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict
    initial begin
        cmd_t                cmd;
        logic [YEAR_W-1:0]   yv;
        logic [MONTH_W-1:0]  mv;
        logic [DAY_W-1:0]    dv;
        logic [AMOUNT_W-1:0] amt;
        int                  pick;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_SET_DATE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: leap rules, clamping, odd days, extremes of every field
        send_item(CMD_ADD_DAYS,   0,     0,  0,  0);      // reset date as is
        send_item(CMD_SET_DATE,   2000,  2,  28, 0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  1);      // 400-year leap day
        send_item(CMD_SET_DATE,   1900,  2,  28, 0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  1);      // century, no leap day
        send_item(CMD_SET_DATE,   2024,  2,  28, 0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  1);
        send_item(CMD_SET_DATE,   16383, 15, 31, 0);      // year, month clamp
        send_item(CMD_SET_DATE,   0,     0,  0,  0);      // month 0, day 0
        send_item(CMD_ADD_DAYS,   0,     0,  0,  0);      // day 0 stays 0
        send_item(CMD_ADD_DAYS,   0,     0,  0,  5);
        send_item(CMD_SET_DATE,   2023,  2,  31, 0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  0);      // excess days roll into March
        send_item(CMD_SET_DATE,   YEAR_W'(YEAR_LIMIT), 12, 31, 0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  1);      // year overflow on day walk
        send_item(CMD_SET_DATE,   YEAR_W'(YEAR_LIMIT), 11, 15, 0);
        send_item(CMD_ADD_MONTHS, 0,     0,  0,  16'hffff);
        send_item(CMD_ADD_YEARS,  0,     0,  0,  16'hffff);
        send_item(CMD_SET_DATE,   2000,  1,  31, 0);
        send_item(CMD_ADD_MONTHS, 0,     0,  0,  1);      // day kept past month end
        send_item(CMD_ADD_MONTHS, 0,     0,  0,  0);
        send_item(CMD_SET_DATE,   10000, 13, 1,  0);
        send_item(CMD_SET_DATE,   9990,  3,  1,  0);
        send_item(CMD_ADD_YEARS,  0,     0,  0,  9);      // lands exactly on the maximum
        send_item(CMD_ADD_YEARS,  0,     0,  0,  0);
        send_item(CMD_SET_DATE,   0,     1,  1,  0);
        send_item(CMD_ADD_DAYS,   0,     0,  0,  16'hffff);

        // Random items, with phases of no idling
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 30 == 0)
                steady = ($urandom_range(0, 2) == 0);
            cmd  = cmd_t'($urandom_range(0, 3));
            yv   = YEAR_W'($urandom);
            mv   = MONTH_W'($urandom);
            dv   = DAY_W'($urandom);
            pick = $urandom_range(0, 9);
            case (cmd)
                CMD_SET_DATE: begin
                    yv  = (pick == 0) ? YEAR_W'($urandom_range(YEAR_LIMIT + 1, 16383)) :
                          (pick < 3)  ? YEAR_W'($urandom_range(YEAR_LIMIT - 20, YEAR_LIMIT)) :
                                        YEAR_W'($urandom_range(0, YEAR_LIMIT));
                    pick = $urandom_range(0, 7);
                    mv  = (pick == 0) ? MONTH_W'($urandom_range(0, 15)) :
                                        MONTH_W'($urandom_range(1, 12));
                    dv  = (pick == 1) ? DAY_W'($urandom_range(0, 31)) :
                                        DAY_W'($urandom_range(1, 28));
                    amt = AMOUNT_W'($urandom);
                end
                CMD_ADD_DAYS: begin
                    amt = (pick == 0) ? AMOUNT_W'($urandom) :
                          (pick < 3)  ? AMOUNT_W'($urandom_range(400, 4000)) :
                                        AMOUNT_W'($urandom_range(0, 400));
                end
                CMD_ADD_MONTHS: begin
                    amt = (pick == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 60));
                end
                default: begin
                    amt = (pick == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 50));
                end
            endcase
            send_item(cmd, yv, mv, dv, amt);
        end
        s_tvalid <= 1'b0;

        // Drain, then a short quiet stretch
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (n_errors == 0 && n_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit: worst case is about 1.2 ms of simulated time
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
